// ----- sv/wtb_pkg.sv -----
// ----------------------------------------------------------------------------
// Wraparound trace buffer package
// Shared sizes, operation codes and transaction payload types.
// ----------------------------------------------------------------------------
package wtb_pkg;

    // Number of entries in the capture memory.
    localparam int DEPTH = 32;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int OFFSET_W = 32;
    localparam int STATUS_W = 8;
    localparam int LIVE_W   = 6;
    localparam int CNT_W    = 32;

    // Derived sizes.
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = OFFSET_W + STATUS_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    // Result kinds.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]            operation;
        logic signed [OFFSET_W-1:0] offset_in;
        logic [STATUS_W-1:0]        status_in;
    } t_in_item;

    typedef struct packed {
        logic                       record_kind;
        logic signed [OFFSET_W-1:0] sample_offset;
        logic [STATUS_W-1:0]        sample_status;
        logic [LIVE_W-1:0]          live_entries;
        logic [CNT_W-1:0]           overwrite_total;
        logic [CNT_W-1:0]           records_seen;
        logic                       last_item;
    } t_out_item;

endpackage

// ----- sv/wtb_chan_if.sv -----
// ----------------------------------------------------------------------------
// Wraparound trace buffer channels
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface wtb_in_if import wtb_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wtb_out_if import wtb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/wtb_ram.sv -----
// ----------------------------------------------------------------------------
// Wraparound trace buffer RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module wtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/wraparound_trace_buffer.sv -----
// ----------------------------------------------------------------------------
// Wraparound trace buffer
// Records offset samples with their status byte into a circular memory and
// plays the live entries back, oldest first, on a dump request.
// ----------------------------------------------------------------------------
// Record and clear transactions are taken at one per cycle when no dump stalls
// the input, and give no result. A dump raises a pending header, loaded into
// the output register once free, then one entry per cycle from the memory read
// port unless the output is held back; input stalls until the last entry is loaded.
// Reset clears the head, both counters and the dump control; the sample memory
// is not cleared and is only ever read at entries written since the last clear.
// ----------------------------------------------------------------------------
module wraparound_trace_buffer import wtb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wtb_in_if.sink    i_in,
    wtb_out_if.source o_out
);

    // Buffer state and dump sequencer.
    logic [ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_rec_cnt, n_rec_cnt;
    logic [CNT_W-1:0]  r_ovw_cnt, n_ovw_cnt;
    logic [LIVE_W-1:0] r_live, n_live;
    logic [LIVE_W-1:0] r_left, n_left;
    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;
    logic              r_hdr_pend, n_hdr_pend;
    logic              r_pend, n_pend;
    logic              r_pend_last, n_pend_last;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              busy;
    logic              in_accept;
    logic              out_free;
    logic              mv_hdr;
    logic              mv_entry;
    logic              rd_issue;
    logic              ram_we;
    logic              full;
    logic [LIVE_W-1:0] live_now;
    logic [DATA_W-1:0] ram_rdata;

    // Handshake and control decode.
    assign busy      = r_hdr_pend || (r_left != '0) || r_pend;
    assign i_in.ready = !busy;
    assign in_accept = i_in.valid && !busy;
    assign out_free  = !r_out_valid || o_out.ready;
    assign mv_hdr    = r_hdr_pend && out_free;
    assign mv_entry  = r_pend && out_free && !r_hdr_pend;
    assign rd_issue  = (r_left != '0) && (!r_pend || mv_entry);
    assign ram_we    = in_accept && (i_in.data.operation == OP_RECORD);
    assign full      = r_rec_cnt >= CNT_W'(DEPTH);
    assign live_now  = full ? LIVE_W'(DEPTH) : r_rec_cnt[LIVE_W-1:0];

    // Sample memory: offset and status side by side.
    wtb_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_head),
        .i_wdata({i_in.data.offset_in, i_in.data.status_in}),
        .i_re   (rd_issue),
        .i_raddr(r_rd_idx),
        .o_rdata(ram_rdata)
    );

    // Next-state logic for the counters, the dump run and the output register.
    always_comb begin
        n_head      = r_head;
        n_rec_cnt   = r_rec_cnt;
        n_ovw_cnt   = r_ovw_cnt;
        n_live      = r_live;
        n_left      = r_left;
        n_rd_idx    = r_rd_idx;
        n_hdr_pend  = r_hdr_pend;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (in_accept) begin
            unique case (i_in.data.operation)
                OP_RECORD: begin
                    n_head = (r_head == ADDR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
                    if (r_rec_cnt != '1) begin
                        n_rec_cnt = r_rec_cnt + 1'b1;
                    end
                    if (full && (r_ovw_cnt != '1)) begin
                        n_ovw_cnt = r_ovw_cnt + 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_head    = '0;
                    n_rec_cnt = '0;
                    n_ovw_cnt = '0;
                end
                OP_DUMP: begin
                    n_hdr_pend = 1'b1;
                    n_live     = live_now;
                    n_left     = live_now;
                    n_rd_idx   = full ? r_head : '0;
                end
                default: begin
                end
            endcase
        end

        // Output register drains when the sink takes the transaction.
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        // Header goes out first.
        if (mv_hdr) begin
            n_hdr_pend                = 1'b0;
            n_out_valid               = 1'b1;
            n_out.record_kind         = KIND_HEADER;
            n_out.sample_offset       = '0;
            n_out.sample_status       = '0;
            n_out.live_entries        = r_live;
            n_out.overwrite_total     = r_ovw_cnt;
            n_out.records_seen        = r_rec_cnt;
            n_out.last_item           = (r_live == '0);
        end

        // A read entry moves from the memory port into the output register.
        if (mv_entry) begin
            n_pend                    = 1'b0;
            n_out_valid               = 1'b1;
            n_out.record_kind         = KIND_ENTRY;
            n_out.sample_offset       = ram_rdata[DATA_W-1:STATUS_W];
            n_out.sample_status       = ram_rdata[STATUS_W-1:0];
            n_out.live_entries        = r_live;
            n_out.overwrite_total     = r_ovw_cnt;
            n_out.records_seen        = r_rec_cnt;
            n_out.last_item           = r_pend_last;
        end

        // Next memory read walks towards the newest entry.
        if (rd_issue) begin
            n_pend      = 1'b1;
            n_pend_last = (r_left == LIVE_W'(1));
            n_left      = r_left - 1'b1;
            n_rd_idx    = (r_rd_idx == ADDR_W'(DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_rec_cnt   <= '0;
            r_ovw_cnt   <= '0;
            r_left      <= '0;
            r_hdr_pend  <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_rec_cnt   <= n_rec_cnt;
            r_ovw_cnt   <= n_ovw_cnt;
            r_left      <= n_left;
            r_hdr_pend  <= n_hdr_pend;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_live      <= n_live;
        r_rd_idx    <= n_rd_idx;
        r_pend_last <= n_pend_last;
        r_out       <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // The memory is never written while a dump run is reading it.
    a_no_write_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !r_pend && (r_left == '0) && !r_hdr_pend)
        else $error("memory write during a dump run");

    // Remaining reads never exceed the entries of the run.
    a_left_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0) |-> (r_left <= r_live) && (r_live <= LIVE_W'(DEPTH)))
        else $error("dump read count out of range");

    // The final entry of a run leaves no reads behind.
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mv_entry && r_pend_last) |-> (r_left == '0) && !rd_issue)
        else $error("last result with entries still pending");

    // An accepted dump always raises its header next.
    a_dump_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in.data.operation == OP_DUMP)) |=> r_hdr_pend)
        else $error("dump accepted without header");

    // A waiting header is loaded as soon as the output register is free.
    a_header_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hdr_pend && out_free) |=> (r_out_valid && (r_out.record_kind == KIND_HEADER)))
        else $error("header not loaded ahead of the entries");

endmodule

// ----- test/wraparound_trace_buffer_tb.sv -----
// ----------------------------------------------------------------------------
// Wraparound trace buffer testbench
// Drives record, clear and dump transactions into the trace buffer and checks
// every dump header and entry against the typed results of its table row or,
// without those, a behavioural model. A short directed table covers the empty
// dump, the field extremes, clearing and the unused operation code. A random
// part follows: record bursts ending in dumps, so the buffer fills and overwrites.
// ----------------------------------------------------------------------------
module wraparound_trace_buffer_tb;
    import wtb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The operation code that the block ignores.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 94;
    localparam int N_DIRECTED   = 16;
    localparam int N_TYPED      = 7;

    typedef struct {
        int        row;
        t_out_item res;
    } t_typed_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wtb_in_if  in_if ();
    wtb_out_if out_if ();

    wraparound_trace_buffer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Directed stimulus, one transaction per row.
    t_in_item directed_items [0:N_DIRECTED-1] = '{
        '{OP_DUMP,   32'sh00000000, 8'h00},  // empty dump straight after reset
        '{OP_UNUSED, 32'shFFFFFFFF, 8'hFF},  // ignored code, all data bits set
        '{OP_RECORD, 32'sh80000000, 8'h00},  // most negative offset
        '{OP_RECORD, 32'sh7FFFFFFF, 8'hFF},  // most positive offset
        '{OP_DUMP,   32'sh00000000, 8'h00},
        '{OP_RECORD, 32'shFFFFFFFF, 8'hAA},
        '{OP_RECORD, 32'sh00000000, 8'h55},
        '{OP_DUMP,   32'sh00000000, 8'h00},
        '{OP_CLEAR,  32'sh00000000, 8'h00},
        '{OP_DUMP,   32'sh00000000, 8'h00},  // empty again after the clear
        '{OP_RECORD, 32'sh12345678, 8'h01},
        '{OP_CLEAR,  32'sh5A5A5A5A, 8'hC3},  // clear carrying stray data
        '{OP_RECORD, 32'shA5A5A5A5, 8'h80},
        '{OP_DUMP,   32'sh00000000, 8'h00},
        '{OP_UNUSED, 32'sh00000000, 8'h00},
        '{OP_DUMP,   32'sh00000000, 8'h00}   // the ignored code left no trace
    };

    // Results that can be stated outright, keyed by their table row.
    t_typed_result typed_results [0:N_TYPED-1] = '{
        '{0,  '{KIND_HEADER, 32'sh00000000, 8'h00, 6'd0, 32'd0, 32'd0, 1'b1}},
        '{4,  '{KIND_HEADER, 32'sh00000000, 8'h00, 6'd2, 32'd0, 32'd2, 1'b0}},
        '{4,  '{KIND_ENTRY,  32'sh80000000, 8'h00, 6'd2, 32'd0, 32'd2, 1'b0}},
        '{4,  '{KIND_ENTRY,  32'sh7FFFFFFF, 8'hFF, 6'd2, 32'd0, 32'd2, 1'b1}},
        '{9,  '{KIND_HEADER, 32'sh00000000, 8'h00, 6'd0, 32'd0, 32'd0, 1'b1}},
        '{13, '{KIND_HEADER, 32'sh00000000, 8'h00, 6'd1, 32'd0, 32'd1, 1'b0}},
        '{13, '{KIND_ENTRY,  32'shA5A5A5A5, 8'h80, 6'd1, 32'd0, 32'd1, 1'b1}}
    };

    // Model of the buffer contents and counters.
    logic signed [OFFSET_W-1:0] model_offset [DEPTH];
    logic [STATUS_W-1:0]        model_status [DEPTH];
    logic [ADDR_W-1:0]          model_head;
    logic [CNT_W-1:0]           model_records;
    logic [CNT_W-1:0]           model_overwrites;

    t_out_item dump_results_due [$];
    int        mismatch_count = 0;
    logic      no_idle = 1'b0;

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one transaction to the model and returns the dump output it gives.
    task automatic trace_buffer_step(input t_in_item item, output t_out_item res[$]);
        logic        was_full;
        int unsigned live;
        int unsigned idx;
        t_out_item   r;
        res = {};
        case (item.operation)
            OP_RECORD: begin
                was_full = (model_records >= DEPTH);
                model_offset[model_head] = item.offset_in;
                model_status[model_head] = item.status_in;
                model_head = (model_head == DEPTH - 1) ? '0 : model_head + 1'b1;
                if (model_records != '1)
                    model_records++;
                // Overwrites keep counting even once the record count has saturated.
                if (was_full && model_overwrites != '1)
                    model_overwrites++;
            end
            OP_CLEAR: begin
                model_head       = '0;
                model_records    = '0;
                model_overwrites = '0;
            end
            OP_DUMP: begin
                live = (model_records < DEPTH) ? model_records : DEPTH;
                idx  = (model_records < DEPTH) ? 0 : model_head;
                r = '0;
                r.record_kind     = KIND_HEADER;
                r.live_entries    = LIVE_W'(live);
                r.overwrite_total = model_overwrites;
                r.records_seen    = model_records;
                r.last_item       = (live == 0);
                res.push_back(r);
                // Entries follow oldest first and repeat the header counts.
                for (int i = 0; i < live; i++) begin
                    r.record_kind   = KIND_ENTRY;
                    r.sample_offset = model_offset[idx];
                    r.sample_status = model_status[idx];
                    r.last_item     = (i == live - 1);
                    res.push_back(r);
                    idx = (idx + 1) % DEPTH;
                end
            end
            default: ;
        endcase
    endtask

    // Sends one transaction and records what it should produce. A row of -1
    // marks a random transaction, which is always checked against the model.
    task automatic issue(input t_in_item item, input int row);
        t_out_item predicted [$];
        int        n_typed;
        while (!no_idle && $urandom_range(0, 99) < 6) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= item;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        trace_buffer_step(item, predicted);
        n_typed = 0;
        foreach (typed_results[k]) begin
            if (typed_results[k].row == row) begin
                dump_results_due.push_back(typed_results[k].res);
                n_typed++;
            end
        end
        if (n_typed == 0)
            foreach (predicted[k])
                dump_results_due.push_back(predicted[k]);
    endtask

    function automatic logic signed [OFFSET_W-1:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return 32'sh80000000;
            1: return 32'sh7FFFFFFF;
            2: return 32'shFFFFFFFF;
            3: return 32'sh00000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: random back-pressure and checking of every result taken.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= no_idle || ($urandom_range(0, 99) >= 6);
            if (out_if.valid && out_if.ready) begin
                if (dump_results_due.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, out_if.data);
                    mismatch_count++;
                end else begin
                    want = dump_results_due.pop_front();
                    check_field("record_kind", 32'(want.record_kind),
                                32'(out_if.data.record_kind));
                    check_field("sample_offset", want.sample_offset,
                                out_if.data.sample_offset);
                    check_field("sample_status", 32'(want.sample_status),
                                32'(out_if.data.sample_status));
                    check_field("live_entries", 32'(want.live_entries),
                                32'(out_if.data.live_entries));
                    check_field("overwrite_total", want.overwrite_total,
                                out_if.data.overwrite_total);
                    check_field("records_seen", want.records_seen,
                                out_if.data.records_seen);
                    check_field("last_item", 32'(want.last_item),
                                32'(out_if.data.last_item));
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random record bursts.
    initial begin
        t_in_item item;
        int       sent;
        int       burst;
        int       burst_len;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data       = '0;
        model_head       = '0;
        model_records    = '0;
        model_overwrites = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int row = 0; row < N_DIRECTED; row++)
            issue(directed_items[row], row);

        // Each burst of records ends in a dump; clears and ignored codes are
        // sprinkled in between. The first burst is long and runs with no
        // idling at all.
        sent  = 0;
        burst = 0;
        while (sent < RANDOM_ITEMS) begin
            no_idle <= (burst == 0);
            if (burst == 0)
                burst_len = $urandom_range(30, 40);
            else
                burst_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                                        : $urandom_range(5, 40);
            if (burst_len > RANDOM_ITEMS - sent - 1)
                burst_len = RANDOM_ITEMS - sent - 1;
            repeat (burst_len) begin
                item.operation = OP_RECORD;
                item.offset_in = pick_offset();
                item.status_in = STATUS_W'($urandom_range(0, 255));
                issue(item, -1);
                sent++;
            end
            item.operation = OP_DUMP;
            item.offset_in = $urandom;
            issue(item, -1);
            sent++;
            // Hold off once until the whole dump has drained.
            if (burst == 1) begin
                in_if.valid <= 1'b0;
                while (dump_results_due.size() != 0)
                    @(posedge i_clk);
            end
            if ($urandom_range(0, 4) == 0) begin
                item.operation = OP_CLEAR;
                item.offset_in = $urandom;
                item.status_in = STATUS_W'($urandom_range(0, 255));
                issue(item, -1);
                sent++;
            end
            if ($urandom_range(0, 5) == 0) begin
                item.operation = OP_UNUSED;
                item.offset_in = $urandom;
                item.status_in = STATUS_W'($urandom_range(0, 255));
                issue(item, -1);
                sent++;
            end
            burst++;
        end
        in_if.valid <= 1'b0;

        while (dump_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
